// ----- hw/rtl/ffed_pkg.sv -----
// ffed_pkg: types, constants and helpers shared by the form field extractor
// used by ffed_step and form_field_extract_decode; no dependencies
package ffed_pkg;

  localparam int unsigned KEY_BYTES_DEF       = 16;
  localparam int unsigned VALUE_LIMIT_MAX_DEF = 4095;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KPOS_W   = 5;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LAST  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 8'd3;

  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] HEX_TEN    = 8'd10;

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_SKIP  = 3'd1,
    PH_VALUE = 3'd2,
    PH_ESC1  = 3'd3,
    PH_ESC2  = 3'd4,
    PH_DRAIN = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic [KPOS_W-1:0]    key_position;
    logic                 key_mismatch;
    logic [3:0]           high_nibble;
    logic [COUNT_W-1:0]   emitted_count;
  } search_state_t;

  typedef struct packed {
    logic                 has_result;
    logic [BYTE_W-1:0]    value_byte;
    logic                 byte_valid;
    logic                 done_res;
    logic                 found;
    logic [COUNT_W-1:0]   value_length;
  } result_t;

  // lenient hex digit, wraps modulo 256
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    if (c > CH_NINE) d = c + HEX_TEN - CH_UPPER_A;
    else d = c - CH_ZERO;
    return d;
  endfunction

endpackage

// ----- hw/rtl/ffed_step.sv -----
// ffed_step: per-byte search and decode step of the form field extractor
// combinational; depends on ffed_pkg
module ffed_step (
  input  ffed_pkg::search_state_t           cur,
  input  logic [ffed_pkg::BYTE_W-1:0]       form_byte,
  input  logic                              last_byte,
  input  logic [ffed_pkg::BYTE_W-1:0]       key_byte,
  input  logic [ffed_pkg::KPOS_W-1:0]       key_len,
  input  logic [ffed_pkg::COUNT_W-1:0]      limit,
  output ffed_pkg::search_state_t           nxt,
  output ffed_pkg::result_t                 res
);
  import ffed_pkg::*;

  logic [COUNT_W-1:0] cnt_inc;
  logic               emit;
  logic               done;
  logic               fnd;
  logic [BYTE_W-1:0]  vb;
  logic               key_match;
  logic               lim_hit;
  logic [BYTE_W-1:0]  digit;

  assign cnt_inc   = cur.emitted_count + COUNT_W'(1);
  assign key_match = !cur.key_mismatch && (cur.key_position == key_len);
  assign lim_hit   = (cnt_inc >= limit);
  assign digit     = hex_digit(form_byte);

  // result side
  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    fnd  = 1'b0;
    vb   = '0;
    case (cur.phase)
      PH_KEY: begin
        if (form_byte == CH_EQUAL) begin
          if (key_match) begin
            if (limit == '0 || last_byte) begin
              done = 1'b1;
              fnd  = 1'b1;
            end
          end else if (last_byte) begin
            done = 1'b1;
          end
        end else begin
          done = last_byte;
        end
      end
      PH_SKIP: begin
        done = last_byte;
      end
      PH_VALUE: begin
        if (form_byte == CH_AMP) begin
          done = 1'b1;
          fnd  = 1'b1;
        end else if (form_byte == CH_PERCENT) begin
          done = last_byte;
          fnd  = last_byte;
        end else begin
          emit = 1'b1;
          vb   = form_byte;
        end
      end
      PH_ESC1: begin
        done = last_byte;
        fnd  = last_byte;
      end
      PH_ESC2: begin
        emit = 1'b1;
        vb   = {cur.high_nibble, 4'h0} | digit;
      end
      default: begin
      end
    endcase
    if (emit && (lim_hit || last_byte)) begin
      done = 1'b1;
      fnd  = 1'b1;
    end
    res.has_result   = emit || done;
    res.value_byte   = vb;
    res.byte_valid   = emit;
    res.done_res     = done;
    res.found        = fnd;
    res.value_length = (fnd || emit) ? (emit ? cnt_inc : cur.emitted_count) : '0;
  end

  // state side
  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_KEY: begin
        if (form_byte == CH_EQUAL) begin
          if (key_match) nxt.phase = PH_VALUE;
          else nxt.phase = PH_SKIP;
        end else if (form_byte == CH_AMP) begin
          nxt.key_position = '0;
          nxt.key_mismatch = 1'b0;
        end else if (cur.key_position < key_len && form_byte == key_byte) begin
          nxt.key_position = cur.key_position + KPOS_W'(1);
        end else begin
          nxt.key_mismatch = 1'b1;
        end
      end
      PH_SKIP: begin
        if (form_byte == CH_AMP) begin
          nxt.phase        = PH_KEY;
          nxt.key_position = '0;
          nxt.key_mismatch = 1'b0;
        end
      end
      PH_VALUE: begin
        if (form_byte == CH_PERCENT) nxt.phase = PH_ESC1;
      end
      PH_ESC1: begin
        nxt.high_nibble = digit[3:0];
        nxt.phase       = PH_ESC2;
      end
      PH_ESC2: begin
        nxt.phase = PH_VALUE;
      end
      default: begin
        nxt.phase = PH_DRAIN;
      end
    endcase
    if (emit) nxt.emitted_count = cnt_inc;
    if (done) nxt.phase = PH_DRAIN;
    if ((done || cur.phase == PH_DRAIN || cur.phase > PH_DRAIN) && last_byte) begin
      nxt.phase         = PH_KEY;
      nxt.key_position  = '0;
      nxt.key_mismatch  = 1'b0;
      nxt.high_nibble   = '0;
      nxt.emitted_count = '0;
    end
  end

endmodule

// ----- hw/rtl/form_field_extract_decode.sv -----
// form_field_extract_decode: top level of the url-encoded form field extractor
// depends on ffed_pkg and ffed_step
//
// usage: form bytes enter one per transaction on the in channel (form_byte,
// last_byte marks the final byte of a form). the block matches each segment's
// key against the configured key and returns decoded value bytes on the out
// channel; the transaction that ends the search carries done_res, found and
// value_length. bytes that produce nothing give no out transaction.
// the configuration channel (cfg_index, cfg_data) is always ready; index 0/1
// load key bytes 0-7 / 8-15, 2 the key length, 3 the value limit; other
// indexes are ignored.
// a byte is captured in the input register, and its result then in the result
// register. throughput: one byte per cycle while the receiver does not stall,
// set by the combinational search step between the two registers.
// reset: clears the search state, the key and key length, and sets the value
// limit to 4095. when the receiver stalls, the result register holds and the
// input register fills, after which in_ready drops until out is taken.
module form_field_extract_decode #(
  parameter int unsigned KEY_BYTES       = ffed_pkg::KEY_BYTES_DEF,
  parameter int unsigned VALUE_LIMIT_MAX = ffed_pkg::VALUE_LIMIT_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ffed_pkg::BYTE_W-1:0]         form_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ffed_pkg::BYTE_W-1:0]         value_byte,
  output logic                                byte_valid,
  output logic                                done_res,
  output logic                                found,
  output logic [ffed_pkg::COUNT_W-1:0]        value_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffed_pkg::CFG_W-1:0]          cfg_data
);
  import ffed_pkg::*;

  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned LIM_CMP_W = 17;
  localparam logic [LIM_CMP_W-1:0] LIMIT_CAP = LIM_CMP_W'(VALUE_LIMIT_MAX);
  localparam logic [KPOS_W-1:0] KEY_LEN_CAP = KPOS_W'(KEY_BYTES);

  logic [BYTE_W-1:0]  key_mem [KEY_BYTES];
  logic [KPOS_W-1:0]  key_length;
  logic [COUNT_W-1:0] value_limit;

  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_last;
  logic               s1_go;

  search_state_t      state;
  search_state_t      state_next;
  result_t            res;

  logic [KPOS_W-1:0]  eff_key_len;
  logic [COUNT_W-1:0] eff_limit;
  logic [KIDX_W-1:0]  key_idx;
  logic [BYTE_W-1:0]  key_byte_sel;

  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < KEY_BYTES; i++) begin : g_key
    localparam logic [CFG_IDX_W-1:0] SRC_IDX = (i < 8) ? REG_KEY_FIRST : REG_KEY_LAST;
    always_ff @(posedge clk) begin
      if (rst) begin
        key_mem[i] <= '0;
      end else if (cfg_valid && cfg_index == SRC_IDX) begin
        key_mem[i] <= cfg_data[(i % 8) * BYTE_W +: BYTE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= '0;
      value_limit <= 12'd4095;
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_LEN) key_length <= cfg_data[KPOS_W-1:0];
      if (cfg_index == REG_LIMIT) value_limit <= cfg_data[COUNT_W-1:0];
    end
  end

  assign eff_key_len = (key_length > KEY_LEN_CAP) ? KEY_LEN_CAP : key_length;
  assign eff_limit   = (LIM_CMP_W'(value_limit) > LIMIT_CAP) ? LIMIT_CAP[COUNT_W-1:0]
                                                             : value_limit;
  assign key_idx      = state.key_position[KIDX_W-1:0];
  assign key_byte_sel = (32'(key_idx) < KEY_BYTES) ? key_mem[key_idx] : '0;

  // input register
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= form_byte;
      s1_last <= last_byte;
    end
  end

  ffed_step u_step (
    .cur       (state),
    .form_byte (s1_byte),
    .last_byte (s1_last),
    .key_byte  (key_byte_sel),
    .key_len   (eff_key_len),
    .limit     (eff_limit),
    .nxt       (state_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_KEY, key_position: '0, key_mismatch: 1'b0,
                 high_nibble: '0, emitted_count: '0};
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.has_result) begin
      value_byte   <= res.value_byte;
      byte_valid   <= res.byte_valid;
      done_res     <= res.done_res;
      found        <= res.found;
      value_length <= res.value_length;
    end
  end

endmodule
